// ----- rtl/core/rmfb_pkg.sv -----
// rmfb_pkg: constants, types and byte/CRC helpers for the RS485 motor frame builder.
// Depends on nothing; imported by rmfb_frame_ser, rs485_motor_frame_builder and rmfb_frame_checker.
`default_nettype none

package rmfb_pkg;

  localparam int MOTOR_SLOTS_DEF = 4;

  localparam int SLOT_W  = 2;
  localparam int DRIVE_W = 16;
  localparam int IDX_W   = 4;

  localparam logic [7:0]  HDR_BYTE = 8'h3E;
  localparam logic [7:0]  SEQ_BYTE = 8'h00;
  localparam logic [7:0]  CMD_BYTE = 8'h55;
  localparam logic [7:0]  LEN_BYTE = 8'h04;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // byte positions within the frame
  localparam logic [IDX_W-1:0] IDX_HDR    = 4'd0;
  localparam logic [IDX_W-1:0] IDX_SEQ    = 4'd1;
  localparam logic [IDX_W-1:0] IDX_ID     = 4'd2;
  localparam logic [IDX_W-1:0] IDX_CMD    = 4'd3;
  localparam logic [IDX_W-1:0] IDX_LEN    = 4'd4;
  localparam logic [IDX_W-1:0] IDX_D0     = 4'd5;
  localparam logic [IDX_W-1:0] IDX_D1     = 4'd6;
  localparam logic [IDX_W-1:0] IDX_D2     = 4'd7;
  localparam logic [IDX_W-1:0] IDX_D3     = 4'd8;
  localparam logic [IDX_W-1:0] IDX_CRC_LO = 4'd9;
  localparam logic [IDX_W-1:0] IDX_CRC_HI = 4'd10;

  typedef struct packed {
    logic [SLOT_W-1:0]         slot;
    logic signed [DRIVE_W-1:0] drive;
  } cmd_t;

  // one byte of CRC-16/MODBUS, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

  function automatic logic [7:0] frame_byte_at(
    input logic [IDX_W-1:0]   idx,
    input logic [SLOT_W-1:0]  slot,
    input logic [DRIVE_W-1:0] drive,
    input logic [15:0]        crc
  );
    logic [7:0] b;
    case (idx)
      IDX_HDR:    b = HDR_BYTE;
      IDX_SEQ:    b = SEQ_BYTE;
      IDX_ID:     b = {{(8-SLOT_W){1'b0}}, slot} + 8'd1;
      IDX_CMD:    b = CMD_BYTE;
      IDX_LEN:    b = LEN_BYTE;
      IDX_D0:     b = drive[7:0];
      IDX_D1:     b = drive[15:8];
      IDX_D2:     b = {8{drive[15]}};
      IDX_D3:     b = {8{drive[15]}};
      IDX_CRC_LO: b = crc[7:0];
      IDX_CRC_HI: b = crc[15:8];
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rmfb_frame_ser.sv -----
// rmfb_frame_ser: frame serializer with registered byte output and running CRC.
// Depends on rmfb_pkg (cmd_t, byte positions, crc_byte, frame_byte_at).
`default_nettype none

module rmfb_frame_ser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire rmfb_pkg::cmd_t cmd,
  output logic               cmd_take,
  output logic               byte_valid,
  input  wire logic          byte_ready,
  output logic [7:0]         byte_data,
  output logic               byte_last
);
  import rmfb_pkg::*;

  logic                      busy;
  logic [IDX_W-1:0]          idx;
  logic [IDX_W-1:0]          idx_next;
  logic [SLOT_W-1:0]         slot;
  logic [DRIVE_W-1:0]        drive;
  logic [15:0]               crc;
  logic [15:0]               crc_next;
  logic [7:0]                out_byte;
  logic [7:0]                byte_next;
  logic                      last;
  logic [SLOT_W-1:0]         sel_slot;
  logic [DRIVE_W-1:0]        sel_drive;
  logic [15:0]               sel_crc;
  logic                      fire;
  logic                      done;
  logic                      advance;

  assign fire     = busy && byte_ready;
  assign done     = fire && (idx == IDX_CRC_HI);
  assign advance  = fire && !done;
  assign cmd_take = cmd_valid && (!busy || done);

  always_comb begin
    sel_slot  = cmd_take ? cmd.slot : slot;
    sel_drive = cmd_take ? cmd.drive : drive;
    sel_crc   = cmd_take ? CRC_INIT : crc;
    idx_next  = cmd_take ? IDX_HDR : idx + 4'd1;
    byte_next = frame_byte_at(idx_next, sel_slot, sel_drive, sel_crc);
    // CRC covers header through last drive byte
    crc_next  = (idx_next <= IDX_D3) ? crc_byte(sel_crc, byte_next) : sel_crc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= IDX_HDR;
      last <= 1'b0;
    end else if (cmd_take || advance) begin
      busy <= 1'b1;
      idx  <= idx_next;
      last <= (idx_next == IDX_CRC_HI);
    end else if (done) begin
      busy <= 1'b0;
      last <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take || advance) begin
      slot     <= sel_slot;
      drive    <= sel_drive;
      crc      <= crc_next;
      out_byte <= byte_next;
    end
  end

  assign byte_valid = busy;
  assign byte_data  = out_byte;
  assign byte_last  = last;

endmodule

`default_nettype wire

// ----- rtl/core/rs485_motor_frame_builder.sv -----
// rs485_motor_frame_builder: top level, command holding register and frame serializer.
// Depends on rmfb_pkg and rmfb_frame_ser.
//
//   channel  | dir | payload                               | marker
//   s_axis   | in  | tdata[1:0] motor_slot, [17:2] drive   | -
//   m_axis   | out | tdata[7:0] frame_byte                 | tlast = frame_end
//
// Each command gives 11 bytes, one per cycle while m_axis_tready is high;
// the sustained command rate is set by the byte output.
// A holding register takes the next command while the current frame drains,
// so frames follow each other with no idle cycle. Commands with a slot at or
// above MOTOR_SLOTS are taken and dropped. Reset clears both valid flags.
`default_nettype none

module rs485_motor_frame_builder #(
  parameter int MOTOR_SLOTS = rmfb_pkg::MOTOR_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [1:0] motor_slot, [17:2] drive_value, rest 0
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] frame_byte
  output logic             m_axis_tlast    // frame_end
);
  import rmfb_pkg::*;

  localparam logic [8:0] SLOT_LIMIT = 9'(MOTOR_SLOTS);

  logic  pend_valid;
  cmd_t  pend;
  cmd_t  in_cmd;
  logic  in_fire;
  logic  slot_ok;
  logic  cmd_take;

  assign in_cmd.slot  = s_axis_tdata[1:0];
  assign in_cmd.drive = s_axis_tdata[17:2];
  assign s_axis_tready = !pend_valid;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign slot_ok = ({{(9-SLOT_W){1'b0}}, in_cmd.slot} < SLOT_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_fire && slot_ok) begin
      pend_valid <= 1'b1;
    end else if (cmd_take) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend <= in_cmd;
    end
  end

  rmfb_frame_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (pend_valid),
    .cmd        (pend),
    .cmd_take   (cmd_take),
    .byte_valid (m_axis_tvalid),
    .byte_ready (m_axis_tready),
    .byte_data  (m_axis_tdata),
    .byte_last  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_idle_after_frame: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast && !pend_valid) |=> !m_axis_tvalid)
    else $error("output not idle after last byte with no command waiting");

  a_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast && pend_valid)
    |=> (m_axis_tvalid && m_axis_tdata == HDR_BYTE && !pend_valid))
    else $error("waiting command did not start next frame");

  a_drop_bad_slot: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !slot_ok) |=> !pend_valid)
    else $error("out-of-range slot entered holding register");
`endif

endmodule

`default_nettype wire

// ----- tb/rmfb_frame_checker.sv -----
// rmfb_frame_checker: watches the command and byte channels of the RS485 frame builder.
// It builds the expected 11-byte frames with their CRC and compares each output item.
// Depends on rmfb_pkg for widths and fixed frame bytes.
`timescale 1ns / 100ps

module rmfb_frame_checker #(
  parameter int MOTOR_SLOTS = rmfb_pkg::MOTOR_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [1:0] motor_slot, [17:2] drive_value, rest 0
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  input  logic        m_axis_tlast,   // frame_end
  output int          fail_count,
  output int          pending_bytes,
  output int          accepted_cmds,
  output int          checked_bytes
);
  import rmfb_pkg::*;

  localparam int FRAME_BYTES = 11;
  localparam int CRC_BYTES   = 9;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } tx_byte_t;

  tx_byte_t expected_tx_bytes[$];

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      if (acc[0] ^ b[i]) begin
        acc = {1'b0, acc[15:1]} ^ CRC_POLY;
      end else begin
        acc = {1'b0, acc[15:1]};
      end
    end
    return acc;
  endfunction

  // queues the bytes of one position command frame; queues nothing for a slot at or above MOTOR_SLOTS
  function automatic void queue_position_frame(input logic [SLOT_W-1:0] slot,
                                               input logic [DRIVE_W-1:0] drive);
    logic [7:0]  fb [0:FRAME_BYTES-1];
    logic [31:0] wide;
    logic [15:0] crc;
    tx_byte_t    item;
    if (int'(slot) >= MOTOR_SLOTS) return;
    wide  = {{16{drive[DRIVE_W-1]}}, drive};
    fb[0] = HDR_BYTE;
    fb[1] = SEQ_BYTE;
    fb[2] = 8'(slot) + 8'd1;
    fb[3] = CMD_BYTE;
    fb[4] = LEN_BYTE;
    fb[5] = wide[7:0];
    fb[6] = wide[15:8];
    fb[7] = wide[23:16];
    fb[8] = wide[31:24];
    crc = CRC_INIT;
    for (int k = 0; k < CRC_BYTES; k++) crc = crc16_update(crc, fb[k]);
    fb[9]  = crc[7:0];
    fb[10] = crc[15:8];
    for (int k = 0; k < FRAME_BYTES; k++) begin
      item.value = fb[k];
      item.last  = (k == FRAME_BYTES - 1);
      expected_tx_bytes.push_back(item);
    end
  endfunction

  initial begin
    fail_count    = 0;
    pending_bytes = 0;
    accepted_cmds = 0;
    checked_bytes = 0;
  end

  always @(posedge clk) begin
    tx_byte_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        queue_position_frame(s_axis_tdata[1:0], s_axis_tdata[17:2]);
        accepted_cmds++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        checked_bytes++;
        if (expected_tx_bytes.size() == 0) begin
          $error("frame_byte unexpected: expected none, actual %02h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_tx_bytes.pop_front();
          if (m_axis_tdata !== want.value) begin
            $error("frame_byte mismatch: expected %02h, actual %02h", want.value, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("frame_end mismatch: expected %0b, actual %0b", want.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
    end
    pending_bytes = expected_tx_bytes.size();
  end

endmodule

// ----- tb/tb.sv -----
// tb: stimulus and verdict for rs485_motor_frame_builder.
// Drives directed and random motor commands under several idle/stall mixes.
// Depends on rmfb_pkg, rs485_motor_frame_builder and rmfb_frame_checker.
`timescale 1ns / 100ps

module tb;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 250;
  localparam int N_DIRECTED  = 20;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  int fail_count;
  int pending_bytes;
  int accepted_cmds;
  int checked_bytes;
  int cycle_count;
  int src_idle_pct;
  int sink_stall_pct;
  int hold_left;
  bit hold_req;
  bit hold_ack;

  logic [15:0] directed_drive [0:N_DIRECTED-1] = '{
    16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFE, 16'h00FF, 16'hFF00,
    16'h5555, 16'hAAAA, 16'h0080, 16'hFF80, 16'h7F00, 16'h8001, 16'h3E55, 16'hC1AA,
    16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000
  };

  rs485_motor_frame_builder u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  rmfb_frame_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .pending_bytes (pending_bytes),
    .accepted_cmds (accepted_cmds),
    .checked_bytes (checked_bytes)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // byte sink: random stalls, plus one long hold when requested
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic logic [15:0] pick_drive();
    logic [15:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'hFFFF;
          default: v = 16'h0000;
        endcase
      end
      1: v = 16'($signed($urandom_range(510)) - 255);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // called at a falling edge; returns at the falling edge after the handshake
  task automatic push_command(input logic [1:0] slot, input logic [15:0] drive);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'b0, drive, slot};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(input int count, input int src_pct, input int snk_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = snk_pct;
    for (int i = 0; i < count; i++) begin
      push_command(2'($urandom_range(3)), pick_drive());
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = 0;
    hold_req       = 1'b0;
    hold_ack       = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      push_command(2'(i % 4), directed_drive[i]);
    end

    // output held off while commands keep coming: input must back up
    hold_req = ~hold_req;
    run_phase(12, 0, 0);

    run_phase(35, 0, 0);
    run_phase(35, 68, 0);
    run_phase(35, 0, 68);
    run_phase(35, 17, 17);
    s_axis_tvalid = 1'b0;

    while (pending_bytes != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Run covered %0d commands (%0d directed, one long output hold, four idle/stall mixes)",
             accepted_cmds, N_DIRECTED);
    $display("Compared %0d frame bytes against predicted frames", checked_bytes);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/rmfb_pkg.sv
rtl/core/rmfb_frame_ser.sv
rtl/core/rs485_motor_frame_builder.sv
tb/rmfb_frame_checker.sv
tb/tb.sv
